// File: rtl/rau_pkg.sv
`default_nettype none

package rau_pkg;

  // Operations of the shared iterative unit
  typedef enum logic [1:0] {
    UOP_GCD,
    UOP_DIV,
    UOP_MUL
  } uop_e;

  // Command from the sequencer to the shared unit
  typedef struct packed {
    logic start;
    uop_e uop;
  } rau_cmd_t;

  // Response from the shared unit
  typedef struct packed {
    logic done;
    logic ovf;
  } rau_rsp_t;

endpackage

`default_nettype wire

// File: rtl/rau_iter.sv
`default_nettype none

// Shared iterative unit: binary gcd, restoring divide, shift-add multiply.
// One step per cycle; result stays on res_o until the next start.
module rau_iter #(
  parameter int W = 64
) (
  input  wire              clk_i,
  input  wire              rst_ni,
  input  wire rau_pkg::rau_cmd_t cmd_i,
  input  wire  [W-1:0]     a_i,
  input  wire  [W-1:0]     b_i,
  output rau_pkg::rau_rsp_t rsp_o,
  output logic [W-1:0]     res_o
);

  localparam int CW = $clog2(W + 1);

  logic            busy_q;
  logic            done_q;
  rau_pkg::uop_e   mode_q;
  logic [CW-1:0]   cnt_q;
  logic [W:0]      hi_q;
  logic [W-1:0]    lo_q;
  logic [W-1:0]    bb_q;
  logic            neg_q;
  logic            ovf_q;

  // gcd datapath
  logic [W-1:0] g_or, g_shl, g_fin, g_dif;
  logic         g_ge;
  // divide datapath
  logic [W:0]   d_sh, d_dif;
  // multiply datapath
  logic [W:0]   m_sum, p_hi;
  logic [W-1:0] m_wrap;
  logic         m_big, m_half, m_ovf;
  // operand magnitudes for multiply
  logic [W-1:0] a_mag, b_mag;

  always_comb begin
    g_or   = lo_q | bb_q;
    g_shl  = g_or << cnt_q;
    g_fin  = (g_or == '0) ? {{(W-1){1'b0}}, 1'b1} : g_shl;
    g_ge   = lo_q >= bb_q;
    g_dif  = g_ge ? (lo_q - bb_q) : (bb_q - lo_q);

    d_sh   = {hi_q[W-1:0], lo_q[W-1]};
    d_dif  = d_sh - {1'b0, bb_q};

    m_sum  = {1'b0, hi_q[W-1:0]} + (lo_q[0] ? {1'b0, bb_q} : '0);
    // product bits 2W-1 down to W-1
    p_hi   = {hi_q[W-1:0], lo_q[W-1]};
    m_big  = |p_hi;
    m_half = (p_hi == {{W{1'b0}}, 1'b1}) && (lo_q[W-2:0] == '0);
    m_ovf  = neg_q ? (m_big && !m_half) : m_big;
    m_wrap = neg_q ? (-lo_q) : lo_q;

    a_mag  = a_i[W-1] ? (-a_i) : a_i;
    b_mag  = b_i[W-1] ? (-b_i) : b_i;
  end

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (cmd_i.start) begin
        busy_q <= 1'b1;
      end else if (busy_q) begin
        case (mode_q)
          rau_pkg::UOP_GCD: begin
            if (lo_q == '0 || bb_q == '0) begin
              busy_q <= 1'b0;
              done_q <= 1'b1;
            end
          end
          rau_pkg::UOP_DIV, rau_pkg::UOP_MUL: begin
            if (cnt_q == '0) begin
              busy_q <= 1'b0;
              done_q <= 1'b1;
            end
          end
          default: busy_q <= 1'b0;
        endcase
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      mode_q <= cmd_i.uop;
      ovf_q  <= 1'b0;
      hi_q   <= '0;
      case (cmd_i.uop)
        rau_pkg::UOP_GCD: begin
          lo_q  <= a_i;
          bb_q  <= b_i;
          cnt_q <= '0;
          neg_q <= 1'b0;
        end
        rau_pkg::UOP_DIV: begin
          lo_q  <= a_i;
          bb_q  <= b_i;
          cnt_q <= CW'(W);
          neg_q <= 1'b0;
        end
        default: begin
          lo_q  <= a_mag;
          bb_q  <= b_mag;
          cnt_q <= CW'(W);
          neg_q <= a_i[W-1] ^ b_i[W-1];
        end
      endcase
    end else if (busy_q) begin
      case (mode_q)
        rau_pkg::UOP_GCD: begin
          if (lo_q == '0 || bb_q == '0) begin
            lo_q <= g_fin;
          end else if (!lo_q[0] && !bb_q[0]) begin
            lo_q  <= lo_q >> 1;
            bb_q  <= bb_q >> 1;
            cnt_q <= cnt_q + CW'(1);
          end else if (!lo_q[0]) begin
            lo_q <= lo_q >> 1;
          end else if (!bb_q[0]) begin
            bb_q <= bb_q >> 1;
          end else if (g_ge) begin
            lo_q <= g_dif;
          end else begin
            bb_q <= g_dif;
          end
        end
        rau_pkg::UOP_DIV: begin
          if (cnt_q != '0) begin
            if (!d_dif[W]) begin
              hi_q <= d_dif;
              lo_q <= {lo_q[W-2:0], 1'b1};
            end else begin
              hi_q <= d_sh;
              lo_q <= {lo_q[W-2:0], 1'b0};
            end
            cnt_q <= cnt_q - CW'(1);
          end
        end
        rau_pkg::UOP_MUL: begin
          if (cnt_q == '0) begin
            lo_q  <= m_wrap;
            ovf_q <= m_ovf;
          end else begin
            hi_q  <= {1'b0, m_sum[W:1]};
            lo_q  <= {m_sum[0], lo_q[W-1:1]};
            cnt_q <= cnt_q - CW'(1);
          end
        end
        default: ;
      endcase
    end
  end

  assign rsp_o = '{done: done_q, ovf: ovf_q};
  assign res_o = lo_q;

endmodule

`default_nettype wire

// File: rtl/rational_arith_unit.sv
// Exact arithmetic on signed fractions a = a_num/a_den and b = b_num/b_den.
// Slave channel: one beat carries the opcode in tuser and both operands in
// tdata. Master channel: one beat per input beat with the normalized result
// (positive denominator, gcd divided out, zero as 0/1), compare flags and
// status (ok, division by zero, overflow).
// Each beat is worked by a sequencer driving one shared iterative unit
// (binary gcd, restoring divider and shift-add multiplier, one step per
// cycle). Both operands, and the result of add, sub, mul and div, are each
// reduced by a gcd and two divides; add/sub/compare add a gcd of the
// denominators, two divides and up to three multiplies. An item finishes
// sooner for small operands since the gcd ends early.
// s_axis_tready is high only while the block is idle; one item is in work
// at a time. The result is held on the master side until taken; the next
// beat is accepted after that. Reset returns the block to idle with no
// result pending.
`default_nettype none

module rational_arith_unit #(
  parameter int WORD_BITS = 64
) (
  input  wire          clk_i,
  input  wire          rst_ni,
  input  wire          s_axis_tvalid,
  output logic         s_axis_tready,
  input  wire  [255:0] s_axis_tdata,  // a_num[63:0], a_den[126:64], b_num[190:127],
                                      // b_den[253:191], zero pad
  input  wire  [2:0]   s_axis_tuser,  // opcode
  output logic         m_axis_tvalid,
  input  wire          m_axis_tready,
  output logic [135:0] m_axis_tdata   // res_num[63:0], res_den[126:64], is_less[127],
                                      // is_equal[128], status[130:129], zero pad
);

  localparam int W = WORD_BITS;
  localparam logic [W-1:0] MIN_W = {1'b1, {(W-1){1'b0}}};
  localparam logic [W-1:0] ONE_W = {{(W-1){1'b0}}, 1'b1};

  localparam logic [2:0] OP_ADD = 3'd0;
  localparam logic [2:0] OP_SUB = 3'd1;
  localparam logic [2:0] OP_MUL = 3'd2;
  localparam logic [2:0] OP_DIV = 3'd3;
  localparam logic [2:0] OP_CMP = 3'd4;
  localparam logic [2:0] OP_NEG = 3'd5;
  localparam logic [2:0] OP_ABS = 3'd6;

  localparam logic [1:0] ST_OK  = 2'd0;
  localparam logic [1:0] ST_DZ  = 2'd1;
  localparam logic [1:0] ST_OVF = 2'd2;

  localparam logic [4:0] S_IDLE = 5'd0;
  localparam logic [4:0] S_N0   = 5'd1;
  localparam logic [4:0] S_N1   = 5'd2;
  localparam logic [4:0] S_N2   = 5'd3;
  localparam logic [4:0] S_N3   = 5'd4;
  localparam logic [4:0] S_WAIT = 5'd5;
  localparam logic [4:0] S_NB   = 5'd6;
  localparam logic [4:0] S_NBD  = 5'd7;
  localparam logic [4:0] S_DISP = 5'd8;
  localparam logic [4:0] S_G    = 5'd9;
  localparam logic [4:0] S_T1   = 5'd10;
  localparam logic [4:0] S_T2   = 5'd11;
  localparam logic [4:0] S_X    = 5'd12;
  localparam logic [4:0] S_Y    = 5'd13;
  localparam logic [4:0] S_M1   = 5'd14;
  localparam logic [4:0] S_D    = 5'd15;
  localparam logic [4:0] S_R    = 5'd16;
  localparam logic [4:0] S_OUT  = 5'd17;

  logic [4:0] state_q, nret_q, wret_q;

  logic [2:0]   op_q;
  logic [W-1:0] an_q, ad_q, bn_q, bd_q;
  logic [W-1:0] nn_q, nd_q, ng_q, nq_q;
  logic [W-1:0] g_q, t1_q, t2_q, x_q;
  logic [W-1:0] rn_q, rd_q;
  logic         ndz_q, dz_a_q, dz_b_q, raw_a0_q;
  logic         dz_q, ovf_q, less_q, eq_q;

  rau_pkg::rau_cmd_t u_cmd_q;
  logic [W-1:0]      u_a_q, u_b_q;
  rau_pkg::rau_rsp_t u_rsp;
  logic [W-1:0]      u_res;

  // input beat fields
  logic [63:0] in_a_num, in_b_num, in_a_den, in_b_den;
  assign in_a_num = s_axis_tdata[63:0];
  assign in_a_den = {1'b0, s_axis_tdata[126:64]};
  assign in_b_num = s_axis_tdata[190:127];
  assign in_b_den = {1'b0, s_axis_tdata[253:191]};

  logic s_acc;
  assign s_axis_tready = (state_q == S_IDLE);
  assign s_acc         = s_axis_tvalid && s_axis_tready;

  // sign handling helpers
  logic         uses_b, dz_now, sum_ovf;
  logic [W-1:0] n1, d1, n1_mag, nn_mag, an_neg, bn_neg, xy_sum;

  always_comb begin
    uses_b  = (op_q <= OP_CMP);
    dz_now  = uses_b ? (dz_a_q | dz_b_q) : raw_a0_q;
    n1      = nd_q[W-1] ? (-nn_q) : nn_q;
    d1      = nd_q[W-1] ? (-nd_q) : nd_q;
    n1_mag  = n1[W-1] ? (-n1) : n1;
    nn_mag  = nn_q[W-1] ? (-nn_q) : nn_q;
    an_neg  = -an_q;
    bn_neg  = -bn_q;
    xy_sum  = x_q + u_res;
    sum_ovf = (x_q[W-1] == u_res[W-1]) && (xy_sum[W-1] != x_q[W-1]);
  end

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      nret_q   <= S_IDLE;
      wret_q   <= S_IDLE;
      u_cmd_q  <= '{start: 1'b0, uop: rau_pkg::UOP_GCD};
      u_a_q    <= '0;
      u_b_q    <= '0;
      op_q     <= '0;
      an_q     <= '0;
      ad_q     <= '0;
      bn_q     <= '0;
      bd_q     <= '0;
      nn_q     <= '0;
      nd_q     <= '0;
      ng_q     <= '0;
      nq_q     <= '0;
      g_q      <= '0;
      t1_q     <= '0;
      t2_q     <= '0;
      x_q      <= '0;
      rn_q     <= '0;
      rd_q     <= '0;
      ndz_q    <= 1'b0;
      dz_a_q   <= 1'b0;
      dz_b_q   <= 1'b0;
      raw_a0_q <= 1'b0;
      dz_q     <= 1'b0;
      ovf_q    <= 1'b0;
      less_q   <= 1'b0;
      eq_q     <= 1'b0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (s_acc) begin
            op_q     <= s_axis_tuser;
            nn_q     <= in_a_num[W-1:0];
            nd_q     <= in_a_den[W-1:0];
            bn_q     <= in_b_num[W-1:0];
            bd_q     <= in_b_den[W-1:0];
            raw_a0_q <= (in_a_den == '0);
            rn_q     <= '0;
            rd_q     <= ONE_W;
            dz_q     <= 1'b0;
            ovf_q    <= 1'b0;
            less_q   <= 1'b0;
            eq_q     <= 1'b0;
            nret_q   <= S_NB;
            state_q  <= S_N0;
          end
        end
        // normalize (nn, nd): sign to numerator, gcd divided out
        S_N0: begin
          if (nd_q == '0) begin
            ndz_q   <= 1'b1;
            nn_q    <= '0;
            nd_q    <= ONE_W;
            state_q <= nret_q;
          end else begin
            ndz_q <= 1'b0;
            if (nd_q[W-1] && (nn_q == MIN_W || nd_q == MIN_W)) begin
              ovf_q <= 1'b1;
            end
            if (nd_q == MIN_W) begin
              nn_q    <= '0;
              nd_q    <= ONE_W;
              state_q <= nret_q;
            end else begin
              nn_q    <= n1;
              nd_q    <= d1;
              u_cmd_q <= '{start: 1'b1, uop: rau_pkg::UOP_GCD};
              u_a_q   <= n1_mag;
              u_b_q   <= d1;
              wret_q  <= S_N1;
              state_q <= S_WAIT;
            end
          end
        end
        S_N1: begin
          ng_q    <= u_res;
          u_cmd_q <= '{start: 1'b1, uop: rau_pkg::UOP_DIV};
          u_a_q   <= nn_mag;
          u_b_q   <= u_res;
          wret_q  <= S_N2;
          state_q <= S_WAIT;
        end
        S_N2: begin
          nq_q    <= u_res;
          u_cmd_q <= '{start: 1'b1, uop: rau_pkg::UOP_DIV};
          u_a_q   <= nd_q;
          u_b_q   <= ng_q;
          wret_q  <= S_N3;
          state_q <= S_WAIT;
        end
        S_N3: begin
          nn_q    <= nn_q[W-1] ? (-nq_q) : nq_q;
          nd_q    <= u_res;
          state_q <= nret_q;
        end
        // wait for the shared unit; start is a single-cycle pulse
        S_WAIT: begin
          u_cmd_q.start <= 1'b0;
          if (u_rsp.done) begin
            ovf_q   <= ovf_q | u_rsp.ovf;
            state_q <= wret_q;
          end
        end
        S_NB: begin
          an_q    <= nn_q;
          ad_q    <= nd_q;
          dz_a_q  <= ndz_q;
          nn_q    <= bn_q;
          nd_q    <= bd_q;
          nret_q  <= S_NBD;
          state_q <= S_N0;
        end
        S_NBD: begin
          bn_q    <= nn_q;
          bd_q    <= nd_q;
          dz_b_q  <= ndz_q;
          state_q <= S_DISP;
        end
        // operation dispatch
        S_DISP: begin
          if (dz_now) begin
            dz_q    <= 1'b1;
            state_q <= S_OUT;
          end else begin
            case (op_q)
              OP_ADD, OP_SUB, OP_CMP: begin
                if (op_q == OP_SUB) begin
                  bn_q <= bn_neg;
                  if (bn_q == MIN_W) begin
                    ovf_q <= 1'b1;
                  end
                end
                u_cmd_q <= '{start: 1'b1, uop: rau_pkg::UOP_GCD};
                u_a_q   <= ad_q;
                u_b_q   <= bd_q;
                wret_q  <= S_G;
                state_q <= S_WAIT;
              end
              OP_MUL, OP_DIV: begin
                u_cmd_q <= '{start: 1'b1, uop: rau_pkg::UOP_MUL};
                u_a_q   <= an_q;
                u_b_q   <= (op_q == OP_MUL) ? bn_q : bd_q;
                wret_q  <= S_M1;
                state_q <= S_WAIT;
              end
              OP_NEG: begin
                rn_q    <= an_neg;
                rd_q    <= ad_q;
                ovf_q   <= ovf_q | (an_q == MIN_W);
                state_q <= S_OUT;
              end
              OP_ABS: begin
                rn_q    <= an_q[W-1] ? an_neg : an_q;
                rd_q    <= ad_q;
                ovf_q   <= ovf_q | (an_q == MIN_W);
                state_q <= S_OUT;
              end
              default: begin
                ovf_q   <= 1'b0;
                state_q <= S_OUT;
              end
            endcase
          end
        end
        // cross products over the gcd of the denominators
        S_G: begin
          g_q     <= u_res;
          u_cmd_q <= '{start: 1'b1, uop: rau_pkg::UOP_DIV};
          u_a_q   <= bd_q;
          u_b_q   <= u_res;
          wret_q  <= S_T1;
          state_q <= S_WAIT;
        end
        S_T1: begin
          t1_q    <= u_res;
          u_cmd_q <= '{start: 1'b1, uop: rau_pkg::UOP_DIV};
          u_a_q   <= ad_q;
          u_b_q   <= g_q;
          wret_q  <= S_T2;
          state_q <= S_WAIT;
        end
        S_T2: begin
          t2_q    <= u_res;
          u_cmd_q <= '{start: 1'b1, uop: rau_pkg::UOP_MUL};
          u_a_q   <= an_q;
          u_b_q   <= t1_q;
          wret_q  <= S_X;
          state_q <= S_WAIT;
        end
        S_X: begin
          x_q     <= u_res;
          u_cmd_q <= '{start: 1'b1, uop: rau_pkg::UOP_MUL};
          u_a_q   <= bn_q;
          u_b_q   <= t2_q;
          wret_q  <= S_Y;
          state_q <= S_WAIT;
        end
        S_Y: begin
          if (op_q == OP_CMP) begin
            less_q  <= $signed(x_q) < $signed(u_res);
            eq_q    <= (an_q == bn_q) && (ad_q == bd_q);
            state_q <= S_OUT;
          end else begin
            x_q     <= xy_sum;
            ovf_q   <= ovf_q | sum_ovf;
            u_cmd_q <= '{start: 1'b1, uop: rau_pkg::UOP_MUL};
            u_a_q   <= ad_q;
            u_b_q   <= t1_q;
            wret_q  <= S_D;
            state_q <= S_WAIT;
          end
        end
        S_M1: begin
          x_q     <= u_res;
          u_cmd_q <= '{start: 1'b1, uop: rau_pkg::UOP_MUL};
          u_a_q   <= ad_q;
          u_b_q   <= (op_q == OP_MUL) ? bd_q : bn_q;
          wret_q  <= S_D;
          state_q <= S_WAIT;
        end
        S_D: begin
          nn_q    <= x_q;
          nd_q    <= u_res;
          nret_q  <= S_R;
          state_q <= S_N0;
        end
        S_R: begin
          rn_q    <= nn_q;
          rd_q    <= nd_q;
          dz_q    <= ndz_q;
          state_q <= S_OUT;
        end
        S_OUT: begin
          if (m_axis_tready) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  rau_iter #(
    .W(W)
  ) u_iter (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (u_cmd_q),
    .a_i    (u_a_q),
    .b_i    (u_b_q),
    .rsp_o  (u_rsp),
    .res_o  (u_res)
  );

  // result beat
  logic [63:0] rn_ext, rd_ext;
  logic [1:0]  status;
  assign rn_ext        = 64'($signed(rn_q));
  assign rd_ext        = 64'($signed(rd_q));
  assign status        = dz_q ? ST_DZ : (ovf_q ? ST_OVF : ST_OK);
  assign m_axis_tvalid = (state_q == S_OUT);
  assign m_axis_tdata  = {5'b0, status, eq_q, less_q, rd_ext[62:0], rn_ext};

  // unit completes only while the sequencer waits on it
  a_done_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    u_rsp.done |-> state_q == S_WAIT)
    else $error("unit done outside wait state");

  // division by zero result is 0/1 with no flags
  a_dz_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && status == ST_DZ |->
      rn_q == '0 && rd_q == ONE_W && !less_q && !eq_q)
    else $error("division by zero result not cleared");

  // compare flags only for compare
  a_flags_cmp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && op_q != OP_CMP |-> !less_q && !eq_q)
    else $error("compare flags set for non-compare opcode");

  // less and equal never together
  a_less_eq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !(less_q && eq_q))
    else $error("less and equal both set");

  // an accepted beat starts operand normalization
  a_accept_norm: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_acc |=> state_q == S_N0 && nret_q == S_NB)
    else $error("accepted beat did not start normalization");

endmodule

`default_nettype wire
